/* rtl/wcis_pkg.sv */
// Shared types and constants for the window code index search block.
package wcis_pkg;

  localparam int SEQ_BITS_DEF = 4096;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_BITS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BITS   = 8'd1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [6:0]  word_index;
    logic [31:0] word_data;
    logic [31:0] query_code;
  } in_item_t;

  typedef struct packed {
    logic [11:0] position;
    logic        found;
    logic [12:0] window_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_B_LO,
    ST_B_HI,
    ST_B_WR,
    ST_S_KEY,
    ST_S_KEYW,
    ST_S_PRD,
    ST_S_CRD,
    ST_S_CMP,
    ST_S_PLACE,
    ST_Q_MID,
    ST_Q_POS,
    ST_Q_CMP,
    ST_RESP
  } state_t;

endpackage

/* rtl/wcis_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module wcis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/window_code_index_search.sv */
// Top level of the window code index search block.
//
// The block keeps a bit sequence in a word store and, on a build, sorts all
// window start positions by window code with an insertion sort kept in a
// position table; a query then binary-searches that table. One item is in
// work at a time and in_ready is low meanwhile. A configuration write is
// taken only while no item is in work, and in that cycle it wins over an
// input transfer. A load or an unused opcode goes straight to its response.
// Each probe of a query reads the table, then reads the code and then
// compares, and a miss ends the search with one more step. A build first
// extracts each window's code from two store words, then sorts with an
// insertion sort whose table moves grow, in the worst case, with the square
// of the window count. All memories have a single read port; none of them
// needs clearing after reset.
module window_code_index_search
  import wcis_pkg::*;
#(
  parameter int SEQ_BITS = SEQ_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int STORE_WORDS = (SEQ_BITS + 31) / 32;
  localparam int SAW = $clog2(STORE_WORDS);
  localparam int PW  = $clog2(SEQ_BITS);
  localparam int CW  = $clog2(SEQ_BITS + 1);

  function automatic logic [31:0] window_code(input logic [31:0] lo, input logic [31:0] hi,
                                               input logic [4:0] off, input logic [5:0] w);
    logic [63:0] v;
    logic [31:0] mask;
    v = {hi, lo} >> off;
    mask = (w >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
    return v[31:0] & mask;
  endfunction

  state_t      state_r, state_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [PW-1:0] slot_r, slot_nxt;
  logic [31:0] key_r, key_nxt;
  logic [PW-1:0] p_r, p_nxt;
  logic [31:0] lo_word_r, lo_word_nxt;
  logic        hi_zero_r, hi_zero_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi1_r, hi1_nxt;
  logic [PW-1:0] mid_r, mid_nxt;
  logic [31:0] query_r, query_nxt;
  logic        ready_r, ready_nxt;
  logic [12:0] seq_bits_r, seq_bits_nxt;
  logic [5:0]  win_bits_r, win_bits_nxt;
  out_item_t   res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  // Memory ports.
  logic            store_we;
  logic [SAW-1:0]  store_wa, store_ra;
  logic [31:0]     store_rd;
  logic            tbl_we;
  logic [PW-1:0]   tbl_wa, tbl_wd, tbl_ra, tbl_rd;
  logic            scr_we;
  logic [PW-1:0]   scr_wa, scr_ra;
  logic [31:0]     scr_wd, scr_rd;

  logic [CW-1:0]   len_eff;
  logic [5:0]      win_eff;
  logic            has_windows;
  logic [CW-1:0]   count;
  logic [CW-1:0]   wi;
  logic            hi_last;
  logic [CW-1:0]   mid_sum;
  logic [31:0]     hi_word;

  wcis_ram #(.WIDTH(32), .DEPTH(STORE_WORDS)) u_store (
    .clk(clk), .wr_en(store_we), .wr_addr(store_wa), .wr_data(in_data.word_data),
    .rd_addr(store_ra), .rd_data(store_rd)
  );

  wcis_ram #(.WIDTH(PW), .DEPTH(SEQ_BITS)) u_table (
    .clk(clk), .wr_en(tbl_we), .wr_addr(tbl_wa), .wr_data(tbl_wd),
    .rd_addr(tbl_ra), .rd_data(tbl_rd)
  );

  // Window codes by start position; valid for the positions of the last build.
  wcis_ram #(.WIDTH(32), .DEPTH(SEQ_BITS)) u_codes (
    .clk(clk), .wr_en(scr_we), .wr_addr(scr_wa), .wr_data(scr_wd),
    .rd_addr(scr_ra), .rd_data(scr_rd)
  );

  always_comb begin
    len_eff = ({19'd0, seq_bits_r} > 32'(SEQ_BITS)) ? CW'(SEQ_BITS) : CW'(seq_bits_r);
    if (win_bits_r == 6'd0) begin
      win_eff = 6'd1;
    end else if (win_bits_r > 6'd32) begin
      win_eff = 6'd32;
    end else begin
      win_eff = win_bits_r;
    end
    has_windows = 32'(len_eff) >= 32'(win_eff);
    count = len_eff - CW'(win_eff) + CW'(1);
    wi = k_r >> 5;
    hi_last = wi == CW'(STORE_WORDS - 1);
    mid_sum = (lo_r + hi1_r - CW'(1)) >> 1;
    hi_word = hi_zero_r ? 32'd0 : store_rd;
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    slot_nxt      = slot_r;
    key_nxt       = key_r;
    p_nxt         = p_r;
    lo_word_nxt   = lo_word_r;
    hi_zero_nxt   = hi_zero_r;
    lo_nxt        = lo_r;
    hi1_nxt       = hi1_r;
    mid_nxt       = mid_r;
    query_nxt     = query_r;
    ready_nxt     = ready_r;
    seq_bits_nxt  = seq_bits_r;
    win_bits_nxt  = win_bits_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    store_we      = 1'b0;
    store_wa      = SAW'(in_data.word_index);
    store_ra      = SAW'(wi);
    tbl_we        = 1'b0;
    tbl_wa        = slot_r;
    tbl_wd        = p_r;
    tbl_ra        = slot_r - PW'(1);
    scr_we        = 1'b0;
    scr_wa        = k_r[PW-1:0];
    scr_wd        = window_code(lo_word_r, hi_word, k_r[4:0], win_eff);
    scr_ra        = k_r[PW-1:0];
    in_ready      = (state_r == ST_IDLE) && !cfg_valid;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          res_nxt   = '0;
          state_nxt = ST_RESP;
          unique case (in_data.opcode)
            OP_LOAD: begin
              store_we  = 32'(in_data.word_index) < 32'(STORE_WORDS);
              ready_nxt = 1'b0;
            end
            OP_BUILD: begin
              if (has_windows) begin
                k_nxt     = '0;
                state_nxt = ST_B_LO;
              end else begin
                ready_nxt = 1'b0;
              end
            end
            OP_QUERY: begin
              if (ready_r && has_windows) begin
                lo_nxt    = '0;
                hi1_nxt   = count;
                query_nxt = in_data.query_code;
                state_nxt = ST_Q_MID;
              end
            end
            default: ;
          endcase
        end
      end
      ST_B_LO: begin
        store_ra  = SAW'(wi);
        state_nxt = ST_B_HI;
      end
      ST_B_HI: begin
        // The word past the end of the store reads as zero.
        store_ra    = hi_last ? '0 : SAW'(wi + CW'(1));
        hi_zero_nxt = hi_last;
        lo_word_nxt = store_rd;
        state_nxt   = ST_B_WR;
      end
      ST_B_WR: begin
        scr_we = 1'b1;
        if (k_r + CW'(1) == count) begin
          k_nxt     = '0;
          state_nxt = ST_S_KEY;
        end else begin
          k_nxt     = k_r + CW'(1);
          state_nxt = ST_B_LO;
        end
      end
      ST_S_KEY: begin
        scr_ra    = k_r[PW-1:0];
        state_nxt = ST_S_KEYW;
      end
      ST_S_KEYW: begin
        key_nxt   = scr_rd;
        slot_nxt  = k_r[PW-1:0];
        state_nxt = (k_r == '0) ? ST_S_PLACE : ST_S_PRD;
      end
      ST_S_PRD: begin
        tbl_ra    = slot_r - PW'(1);
        state_nxt = ST_S_CRD;
      end
      ST_S_CRD: begin
        p_nxt     = tbl_rd;
        scr_ra    = tbl_rd;
        state_nxt = ST_S_CMP;
      end
      ST_S_CMP, ST_S_PLACE: begin
        tbl_we = 1'b1;
        if (state_r == ST_S_CMP && scr_rd > key_r) begin
          // Shift the larger entry up one slot and keep walking down.
          tbl_wd    = p_r;
          slot_nxt  = slot_r - PW'(1);
          state_nxt = (slot_r == PW'(1)) ? ST_S_PLACE : ST_S_PRD;
        end else begin
          tbl_wd = k_r[PW-1:0];
          if (k_r + CW'(1) == count) begin
            ready_nxt              = 1'b1;
            res_nxt.window_count   = 13'(count);
            state_nxt              = ST_RESP;
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = ST_S_KEY;
          end
        end
      end
      ST_Q_MID: begin
        if (lo_r >= hi1_r) begin
          state_nxt = ST_RESP;
        end else begin
          mid_nxt   = mid_sum[PW-1:0];
          tbl_ra    = mid_sum[PW-1:0];
          state_nxt = ST_Q_POS;
        end
      end
      ST_Q_POS: begin
        p_nxt     = tbl_rd;
        scr_ra    = tbl_rd;
        state_nxt = ST_Q_CMP;
      end
      ST_Q_CMP: begin
        if (query_r > scr_rd) begin
          lo_nxt    = CW'(mid_r) + CW'(1);
          state_nxt = ST_Q_MID;
        end else if (query_r < scr_rd) begin
          hi1_nxt   = CW'(mid_r);
          state_nxt = ST_Q_MID;
        end else begin
          res_nxt.position = 12'(p_r);
          res_nxt.found    = 1'b1;
          state_nxt        = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SEQUENCE_BITS: begin
          seq_bits_nxt = cfg_data[12:0];
          ready_nxt    = 1'b0;
        end
        REG_WINDOW_BITS: begin
          win_bits_nxt = cfg_data[5:0];
          ready_nxt    = 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign cfg_ready = state_r == ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ready_r     <= 1'b0;
      seq_bits_r  <= 13'd4096;
      win_bits_r  <= 6'd16;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ready_r     <= ready_nxt;
      seq_bits_r  <= seq_bits_nxt;
      win_bits_r  <= win_bits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    slot_r     <= slot_nxt;
    key_r      <= key_nxt;
    p_r        <= p_nxt;
    lo_word_r  <= lo_word_nxt;
    hi_zero_r  <= hi_zero_nxt;
    lo_r       <= lo_nxt;
    hi1_r      <= hi1_nxt;
    mid_r      <= mid_nxt;
    query_r    <= query_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* rtl/wcis_checker.sv */
// Port-level checks for the window code index search block and their bind.
module wcis_checker
  import wcis_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A result that is not taken holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // After an input transfer the block is busy in the cycle that follows.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // A query hit never reports a window count.
  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.window_count == 13'd0)
    else $error("hit carries a window count");

  // Without a hit the position reads zero.
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.position == 12'd0)
    else $error("miss carries a position");

endmodule

bind window_code_index_search wcis_checker u_wcis_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

/* tb/sv/testbench.sv */
// Self-checking testbench for the window code index search block.
`timescale 1ns / 1ps

module testbench;
  import wcis_pkg::*;

  localparam int STORE_DEPTH = SEQ_BITS_DEF / 32;

  class index_scoreboard;
    logic [31:0] seq_words[STORE_DEPTH];
    int          sorted_pos[SEQ_BITS_DEF];
    logic [31:0] window_code[SEQ_BITS_DEF];
    bit          table_valid;
    int          seq_len_reg;
    int          win_len_reg;
    out_item_t   expected_q[$];
    int          errors;

    function new();
      foreach (seq_words[i]) seq_words[i] = '0;
      table_valid = 0;
      seq_len_reg = 4096;
      win_len_reg = 16;
      errors      = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    function int seq_len();
      return (seq_len_reg > SEQ_BITS_DEF) ? SEQ_BITS_DEF : seq_len_reg;
    endfunction

    function int win_len();
      if (win_len_reg == 0) return 1;
      return (win_len_reg > 32) ? 32 : win_len_reg;
    endfunction

    function logic [31:0] code_at(int p, int w);
      logic [63:0] pair;
      logic [63:0] mask;
      int          wi;
      wi   = p >> 5;
      pair = {((wi + 1 < STORE_DEPTH) ? seq_words[wi + 1] : 32'h0), seq_words[wi]};
      pair = pair >> (p & 31);
      mask = (w >= 32) ? 64'hFFFF_FFFF : ((64'h1 << w) - 64'h1);
      return pair[31:0] & mask[31:0];
    endfunction

    function int sort_windows();
      int          n;
      int          w;
      int          slot;
      logic [31:0] key;
      n = seq_len();
      w = win_len();
      if (n < w) begin
        table_valid = 0;
        return 0;
      end
      for (int k = 0; k <= n - w; k++) window_code[k] = code_at(k, w);
      for (int k = 0; k <= n - w; k++) begin
        key  = window_code[k];
        slot = k;
        while (slot > 0 && window_code[sorted_pos[slot - 1]] > key) begin
          sorted_pos[slot] = sorted_pos[slot - 1];
          slot--;
        end
        sorted_pos[slot] = k;
      end
      table_valid = 1;
      return n - w + 1;
    endfunction

    function bit search_code(logic [31:0] code, output int pos);
      int          lo, hi, mid, w;
      logic [31:0] c;
      pos = 0;
      w   = win_len();
      if (!table_valid || seq_len() < w) return 0;
      lo = 0;
      hi = seq_len() - w;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        c   = code_at(sorted_pos[mid], w);
        if (code > c) lo = mid + 1;
        else if (code < c) hi = mid - 1;
        else begin
          pos = sorted_pos[mid];
          return 1;
        end
      end
      return 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_SEQUENCE_BITS) begin
        seq_len_reg = val[12:0];
        table_valid = 0;
      end else if (idx == REG_WINDOW_BITS) begin
        win_len_reg = val[5:0];
        table_valid = 0;
      end
    endfunction

    function void note_input(in_item_t it);
      out_item_t e;
      int        pos;
      e = '0;
      case (it.opcode)
        OP_LOAD: begin
          seq_words[it.word_index] = it.word_data;
          table_valid = 0;
        end
        OP_BUILD: e.window_count = 13'(sort_windows());
        OP_QUERY: begin
          e.found    = search_code(it.query_code, pos);
          e.position = 12'(pos);
        end
        default: ;
      endcase
      expected_q.push_back(e);
    endfunction

    task check_result(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected: %p", got));
      end else begin
        e = expected_q.pop_front();
        if (got.position !== e.position)
          report($sformatf("position %0d, expected %0d", got.position, e.position));
        if (got.found !== e.found)
          report($sformatf("found %0b, expected %0b", got.found, e.found));
        if (got.window_count !== e.window_count)
          report($sformatf("window_count %0d, expected %0d",
                           got.window_count, e.window_count));
      end
    endtask
  endclass

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  in_valid = 0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 0;
  out_item_t             out_data;
  logic                  cfg_valid = 0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  index_scoreboard sb = new();
  bit calm = 0;
  bit hold_out = 0;
  int out_stall = 0;

  window_code_index_search uut (.*);

  always #1 clk = ~clk;

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Transfers are observed here, at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_data);
    if (rst_n && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
      out_stall = calm ? 0 : $urandom_range(0, 14);
    end
  end

  always @(negedge clk) begin
    if (hold_out) out_ready <= 0;
    else if (out_stall > 0) begin
      out_ready <= 0;
      out_stall--;
    end else out_ready <= 1;
  end

  task hold_results(int cycles);
    hold_out = 1;
    repeat (cycles) @(negedge clk);
    hold_out = 0;
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task send_item(in_item_t it);
    int gap;
    bit rdy;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    @(negedge clk);
  endtask

  task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    bit rdy;
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // Pauses the input side until every result is back and the block is idle.
  task drain();
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function in_item_t make_op(opcode_t op, int idx, logic [31:0] dat, logic [31:0] code);
    in_item_t it;
    it.opcode     = op;
    it.word_index = 7'(idx);
    it.word_data  = dat;
    it.query_code = code;
    return it;
  endfunction

  function logic [31:0] pick_code();
    int n, w;
    n = sb.seq_len();
    w = sb.win_len();
    if (n >= w && $urandom_range(0, 9) < 7)
      return sb.code_at($urandom_range(0, n - w), w);
    return $urandom;
  endfunction

  task random_phase(int count);
    in_item_t it;
    int       r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (k == 0 || r < 4) it = make_op(OP_BUILD, $urandom, $urandom, $urandom);
      else if (r < 12) begin
        it = make_op(OP_LOAD, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                           : $urandom_range(0, 3),
                     $urandom, $urandom);
      end else if (r < 14) it = make_op(OP_NONE, $urandom, $urandom, $urandom);
      else it = make_op(OP_QUERY, $urandom, $urandom, pick_code());
      send_item(it);
      // A build after about half of the loads keeps the search path busy.
      if (it.opcode == OP_LOAD && $urandom_range(0, 1))
        send_item(make_op(OP_BUILD, $urandom, $urandom, $urandom));
    end
  endtask

  initial begin
    int len, win;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed part: uniform sequences keep the large builds cheap.
    calm = 1;
    for (int i = 0; i < STORE_DEPTH; i++)
      send_item(make_op(OP_LOAD, i, 32'h0, 32'h0));
    send_item(make_op(OP_QUERY, 0, 0, 32'h0));
    send_item(make_op(OP_NONE, 127, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    drain();
    write_cfg(REG_SEQUENCE_BITS, 16'hFFFF);
    write_cfg(REG_WINDOW_BITS, 16'h0000);
    send_item(make_op(OP_BUILD, 0, 0, 0));
    send_item(make_op(OP_QUERY, 0, 0, 32'h0));
    send_item(make_op(OP_QUERY, 0, 0, 32'h1));
    drain();
    write_cfg(REG_SEQUENCE_BITS, 16'd4096);
    write_cfg(REG_WINDOW_BITS, 16'd63);
    send_item(make_op(OP_BUILD, 0, 0, 0));
    send_item(make_op(OP_QUERY, 0, 0, 32'h0));
    send_item(make_op(OP_QUERY, 0, 0, 32'hFFFF_FFFF));
    send_item(make_op(OP_LOAD, 5, 32'hFFFF_FFFF, 0));
    send_item(make_op(OP_QUERY, 0, 0, 32'h0));
    drain();
    write_cfg(REG_SEQUENCE_BITS, 16'd5);
    write_cfg(REG_WINDOW_BITS, 16'd16);
    send_item(make_op(OP_BUILD, 0, 0, 0));
    send_item(make_op(OP_QUERY, 0, 0, 32'h0));
    drain();
    write_cfg(REG_SEQUENCE_BITS, 16'd64);
    write_cfg(REG_WINDOW_BITS, 16'd32);
    for (int i = 0; i < 4; i++)
      send_item(make_op(OP_LOAD, i, $urandom, 0));
    send_item(make_op(OP_BUILD, 0, 0, 0));
    send_item(make_op(OP_QUERY, 0, 0, sb.code_at(32, 32)));
    send_item(make_op(OP_QUERY, 0, 0, 32'hFFFF_FFFF));
    drain();

    // Random phases with small sequences, so builds stay short.
    for (int ph = 0; ph < 14; ph++) begin
      calm = ($urandom_range(0, 3) == 0);
      case (ph)
        0: begin len = 1;  win = 1;  end
        1: begin len = 96; win = 32; end
        2: begin len = 96; win = 0;  end
        3: begin len = 8;  win = 9;  end
        default: begin
          len = $urandom_range(1, 96);
          win = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 12);
        end
      endcase
      write_cfg(REG_SEQUENCE_BITS, {3'($urandom), 13'(len)});
      write_cfg(REG_WINDOW_BITS, {10'($urandom), 6'(win)});
      for (int i = 0; i < 4; i++)
        send_item(make_op(OP_LOAD, i, $urandom, $urandom));
      if (ph == 5) fork hold_results(400); join_none
      random_phase(80);
      drain();
    end

    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
